FILE: rtl/spt_pkg.sv
package spt_pkg;

	// Rotation datapath: cosine and sine in Q16 with headroom for the CORDIC gain.
	localparam int XY_W = 19;
	// Residual angle in 32-bit turn fractions.
	localparam int Z_W = 32;
	localparam int CORDIC_STEPS = 16;

	// Gain-compensated 1.0 in Q16.
	localparam logic signed [XY_W-1:0] CORDIC_X0 = 19'sd39797;

	// Arctangent of 2^-i as a fraction of one turn times 2^32.
	localparam logic [Z_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
	};

	// 1/sqrt(3) in Q0.16.
	localparam logic signed [17:0] INV_SQRT3_Q16 = 18'sd37837;
	// Half an LSB ahead of a 16-bit right shift.
	localparam int ROUND_HALF = 32768;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ENABLE     = 1'b0,
		CFG_INPUT_MODE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic enable;
		logic input_mode;
	} cfg_t;

endpackage

FILE: rtl/spt_if.sv
interface spt_in_if #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ANGLE_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] phase_a;
	logic signed [SAMPLE_WIDTH-1:0] phase_b;
	logic signed [SAMPLE_WIDTH-1:0] phase_c;
	logic [ANGLE_WIDTH-1:0] angle;

	modport source (output valid, output phase_a, output phase_b, output phase_c,
		output angle, input ready);
	modport sink (input valid, input phase_a, input phase_b, input phase_c,
		input angle, output ready);
endinterface

interface spt_out_if #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ANGLE_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH+1:0] pos_d;
	logic signed [SAMPLE_WIDTH+1:0] pos_q;
	logic signed [SAMPLE_WIDTH+1:0] neg_d;
	logic signed [SAMPLE_WIDTH+1:0] neg_q;
	logic signed [SAMPLE_WIDTH-1:0] zero_seq;
	logic [ANGLE_WIDTH-1:0] neg_angle;

	modport source (output valid, output pos_d, output pos_q, output neg_d,
		output neg_q, output zero_seq, output neg_angle, input ready);
	modport sink (input valid, input pos_d, input pos_q, input neg_d,
		input neg_q, input zero_seq, input neg_angle, output ready);
endinterface

FILE: rtl/spt_front.sv
module spt_front #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spt_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] phase_a,
	input  logic signed [SAMPLE_WIDTH-1:0] phase_b,
	input  logic signed [SAMPLE_WIDTH-1:0] phase_c,
	input  logic [ANGLE_WIDTH-1:0]        angle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_WIDTH:0]  alpha,
	output logic signed [SAMPLE_WIDTH:0]  beta,
	output logic signed [SAMPLE_WIDTH-1:0] zero_seq,
	output logic [ANGLE_WIDTH-1:0]        neg_angle,
	output logic                          flip,
	output logic [ANGLE_WIDTH-1:0]        turn
);
	localparam int SW = SAMPLE_WIDTH;
	localparam int AW = ANGLE_WIDTH;
	localparam int M_W = SW + 3;
	localparam int UW = SW + 5;
	localparam int PB_W = SW + 18;

	// floor(u/3) = (u * ceil(2^(UW+1)/3)) >> (UW+1) holds exactly for u < 2^UW.
	localparam logic [UW+1:0] DIV3_POW = {1'b1, {(UW+1){1'b0}}};
	localparam logic [UW+1:0] DIV3_FULL = (DIV3_POW + (UW+2)'(2)) / (UW+2)'(3);
	localparam logic [UW-1:0] DIV3_M = DIV3_FULL[UW-1:0];
	// The numerator is lifted by a multiple of three so that it is never negative.
	localparam logic [UW-1:0] DIV3_OFS = (UW)'(3) << (SW + 2);
	localparam logic signed [UW-1:0] Q_OFS = (UW)'(1) << (SW + 2);

	logic en_s1, en_s2, en_s3;
	logic v_s1, v_s2, v_s3;

	logic signed [M_W-1:0] a_x, b_x, c_x, m_alpha, m_zero;
	logic signed [SW:0] diff;

	logic signed [M_W-1:0] m_alpha_s1, m_zero_s1;
	logic signed [SW:0] diff_s1;
	logic signed [SW-1:0] a_s1, b_s1;
	logic mode_s1, flip_s1;
	logic [AW-1:0] nang_s1, turn_s1;

	logic [UW-1:0] u_alpha, u_zero;
	logic [2*UW-1:0] pa_s2, pz_s2;
	logic signed [PB_W-1:0] pb_s2;
	logic signed [SW-1:0] a_s2, b_s2;
	logic mode_s2, flip_s2;
	logic [AW-1:0] nang_s2, turn_s2;

	logic signed [UW-1:0] qa, qz;
	logic signed [PB_W-1:0] rb;

	logic signed [SW:0] alpha_s3, beta_s3;
	logic signed [SW-1:0] zero_s3;
	logic flip_s3;
	logic [AW-1:0] nang_s3, turn_s3;

	assign en_s3 = !v_s3 || out_ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// Both divisions by three round to nearest as floor((n + 1) / 3).
	assign a_x = M_W'(phase_a);
	assign b_x = M_W'(phase_b);
	assign c_x = M_W'(phase_c);
	assign m_alpha = (a_x <<< 1) - b_x - c_x + M_W'(1);
	assign m_zero = a_x + b_x + c_x + M_W'(1);
	assign diff = (SW+1)'(phase_b) - (SW+1)'(phase_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid && cfg.enable;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			m_alpha_s1 <= m_alpha;
			m_zero_s1 <= m_zero;
			diff_s1 <= diff;
			a_s1 <= phase_a;
			b_s1 <= phase_b;
			mode_s1 <= cfg.input_mode;
			nang_s1 <= AW'(0) - angle;
			// Angles in the left half turn are folded by half a turn and the
			// results negated.
			flip_s1 <= angle[AW-1] ^ angle[AW-2];
			turn_s1 <= {angle[AW-2], angle[AW-2:0]};
		end
	end

	assign u_alpha = UW'(m_alpha_s1) + DIV3_OFS;
	assign u_zero = UW'(m_zero_s1) + DIV3_OFS;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pa_s2 <= (2*UW)'(u_alpha) * (2*UW)'(DIV3_M);
			pz_s2 <= (2*UW)'(u_zero) * (2*UW)'(DIV3_M);
			pb_s2 <= PB_W'(diff_s1) * PB_W'(spt_pkg::INV_SQRT3_Q16);
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			mode_s2 <= mode_s1;
			nang_s2 <= nang_s1;
			flip_s2 <= flip_s1;
			turn_s2 <= turn_s1;
		end
	end

	assign qa = $signed({1'b0, pa_s2[2*UW-1:UW+1]}) - Q_OFS;
	assign qz = $signed({1'b0, pz_s2[2*UW-1:UW+1]}) - Q_OFS;
	assign rb = pb_s2 + PB_W'(spt_pkg::ROUND_HALF);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			if (mode_s2) begin
				alpha_s3 <= (SW+1)'(a_s2);
				beta_s3 <= (SW+1)'(b_s2);
				zero_s3 <= '0;
			end else begin
				alpha_s3 <= qa[SW:0];
				beta_s3 <= rb[SW+16:16];
				zero_s3 <= qz[SW-1:0];
			end
			nang_s3 <= nang_s2;
			flip_s3 <= flip_s2;
			turn_s3 <= turn_s2;
		end
	end

	assign out_valid = v_s3;
	assign alpha = alpha_s3;
	assign beta = beta_s3;
	assign zero_seq = zero_s3;
	assign neg_angle = nang_s3;
	assign flip = flip_s3;
	assign turn = turn_s3;

endmodule

FILE: rtl/spt_cordic_cell.sv
module spt_cordic_cell #(
	parameter int STEP = 0,
	parameter int PAY_W = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [spt_pkg::XY_W-1:0]    x_in,
	input  logic signed [spt_pkg::XY_W-1:0]    y_in,
	input  logic signed [spt_pkg::Z_W-1:0]     z_in,
	input  logic [PAY_W-1:0]                   pay_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [spt_pkg::XY_W-1:0]    x_out,
	output logic signed [spt_pkg::XY_W-1:0]    y_out,
	output logic signed [spt_pkg::Z_W-1:0]     z_out,
	output logic [PAY_W-1:0]                   pay_out
);
	localparam logic signed [spt_pkg::Z_W-1:0] ATAN = spt_pkg::ATAN_TURNS[STEP];

	logic en;
	logic v_s1;
	logic signed [spt_pkg::XY_W-1:0] dx, dy, x_nx, y_nx, x_s1, y_s1;
	logic signed [spt_pkg::Z_W-1:0] z_nx, z_s1;
	logic [PAY_W-1:0] pay_s1;

	assign en = !v_s1 || out_ready;
	assign in_ready = en;

	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;

	// Rotate towards a zero residual angle.
	always_comb begin
		if (!z_in[spt_pkg::Z_W-1]) begin
			x_nx = x_in - dx;
			y_nx = y_in + dy;
			z_nx = z_in - ATAN;
		end else begin
			x_nx = x_in + dx;
			y_nx = y_in - dy;
			z_nx = z_in + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_nx;
			y_s1 <= y_nx;
			z_s1 <= z_nx;
			pay_s1 <= pay_in;
		end
	end

	assign out_valid = v_s1;
	assign x_out = x_s1;
	assign y_out = y_s1;
	assign z_out = z_s1;
	assign pay_out = pay_s1;

endmodule

FILE: rtl/spt_back.sv
module spt_back #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [spt_pkg::XY_W-1:0] x,
	input  logic signed [spt_pkg::XY_W-1:0] y,
	input  logic signed [SAMPLE_WIDTH:0]    alpha,
	input  logic signed [SAMPLE_WIDTH:0]    beta,
	input  logic signed [SAMPLE_WIDTH-1:0]  zero_in,
	input  logic [ANGLE_WIDTH-1:0]          nang_in,
	input  logic                            flip,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [SAMPLE_WIDTH+1:0]  pos_d,
	output logic signed [SAMPLE_WIDTH+1:0]  pos_q,
	output logic signed [SAMPLE_WIDTH+1:0]  neg_d,
	output logic signed [SAMPLE_WIDTH+1:0]  neg_q,
	output logic signed [SAMPLE_WIDTH-1:0]  zero_seq,
	output logic [ANGLE_WIDTH-1:0]          neg_angle
);
	localparam int SW = SAMPLE_WIDTH;
	localparam int AW = ANGLE_WIDTH;
	localparam int DQ_W = SW + 2;
	localparam int P_W = SW + 1 + spt_pkg::XY_W;
	localparam int SUM_W = P_W + 1;
	localparam int SH_W = SUM_W - 16;
	localparam logic signed [SH_W-1:0] DQ_MAX =
		{{(SH_W-DQ_W+1){1'b0}}, {(DQ_W-1){1'b1}}};
	localparam logic signed [SH_W-1:0] DQ_MIN =
		{{(SH_W-DQ_W+1){1'b1}}, {(DQ_W-1){1'b0}}};

	function automatic logic signed [DQ_W-1:0] sat_round(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		logic signed [SH_W-1:0] sh;
		r = v + SUM_W'(spt_pkg::ROUND_HALF);
		sh = r[SUM_W-1:16];
		if (sh > DQ_MAX) begin
			return DQ_MAX[DQ_W-1:0];
		end else if (sh < DQ_MIN) begin
			return DQ_MIN[DQ_W-1:0];
		end
		return sh[DQ_W-1:0];
	endfunction

	logic en_s1, en_s2, en_s3;
	logic v_s1, v_s2, v_s3;

	logic signed [spt_pkg::XY_W-1:0] c_s1, s_s1;
	logic signed [SW:0] alpha_s1, beta_s1;
	logic signed [SW-1:0] zero_s1, zero_s2, zero_s3;
	logic [AW-1:0] nang_s1, nang_s2, nang_s3;

	logic signed [P_W-1:0] ac_s2, bs_s2, bc_s2, as_s2;
	logic signed [DQ_W-1:0] pos_d_s3, pos_q_s3, neg_d_s3, neg_q_s3;

	assign en_s3 = !v_s3 || out_ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// The fold is undone on cosine and sine before the products, not after
	// rounding, so that rounding sees the true sign.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			c_s1 <= flip ? -x : x;
			s_s1 <= flip ? -y : y;
			alpha_s1 <= alpha;
			beta_s1 <= beta;
			zero_s1 <= zero_in;
			nang_s1 <= nang_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ac_s2 <= P_W'(alpha_s1) * P_W'(c_s1);
			bs_s2 <= P_W'(beta_s1) * P_W'(s_s1);
			bc_s2 <= P_W'(beta_s1) * P_W'(c_s1);
			as_s2 <= P_W'(alpha_s1) * P_W'(s_s1);
			zero_s2 <= zero_s1;
			nang_s2 <= nang_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			pos_d_s3 <= sat_round(SUM_W'(ac_s2) + SUM_W'(bs_s2));
			pos_q_s3 <= sat_round(SUM_W'(bc_s2) - SUM_W'(as_s2));
			neg_d_s3 <= sat_round(SUM_W'(ac_s2) - SUM_W'(bs_s2));
			neg_q_s3 <= sat_round(SUM_W'(as_s2) + SUM_W'(bc_s2));
			zero_s3 <= zero_s2;
			nang_s3 <= nang_s2;
		end
	end

	assign out_valid = v_s3;
	assign pos_d = pos_d_s3;
	assign pos_q = pos_q_s3;
	assign neg_d = neg_d_s3;
	assign neg_q = neg_q_s3;
	assign zero_seq = zero_s3;
	assign neg_angle = nang_s3;

endmodule

FILE: rtl/three_phase_sequence_park_transform_core.sv
// Clarke transform followed by positive- and negative-sequence Park rotation.
// Input channel "sample" carries one three-phase sample (or alpha and beta) and
// the PLL angle; output channel "result" carries the four d/q components, the
// zero-sequence mean and the negated angle. Both use valid/ready.
// Register 0 (enable) drops accepted items without a result when cleared;
// register 1 selects alpha/beta input. Write them only while no item is in
// flight.
// An accepted item passes three Clarke stages, one stage for each of the 16
// CORDIC rotations, and three stages for the rotation products, rounding and
// saturation. One item is accepted every cycle except when a stall has filled
// every stage; every stage holds one item and passes it on when the next is
// free. When the receiver stalls the output register holds its result and
// the stages behind it keep filling; sample.ready falls only once every stage
// is occupied. Reset empties all stages and sets enable to 1 and input mode to
// abc; no clearing pass is needed.
module three_phase_sequence_park_transform_core #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [spt_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [spt_pkg::CFG_DATA_W-1:0]   cfg_data,
	spt_in_if.sink                           sample,
	spt_out_if.source                        result
);
	localparam int SW = SAMPLE_WIDTH;
	localparam int AW = ANGLE_WIDTH;
	localparam int STEPS = spt_pkg::CORDIC_STEPS;
	// Carried alongside the rotation: flip, negated angle, zero, beta, alpha.
	localparam int PAY_W = 1 + AW + SW + 2 * (SW + 1);

	spt_pkg::cfg_t cfg_q;

	logic front_valid, front_ready;
	logic signed [SW:0] f_alpha, f_beta;
	logic signed [SW-1:0] f_zero;
	logic [AW-1:0] f_nang, f_turn;
	logic f_flip;

	logic chain_valid [STEPS+1];
	logic chain_ready [STEPS+1];
	logic signed [spt_pkg::XY_W-1:0] chain_x [STEPS+1];
	logic signed [spt_pkg::XY_W-1:0] chain_y [STEPS+1];
	logic signed [spt_pkg::Z_W-1:0] chain_z [STEPS+1];
	logic [PAY_W-1:0] chain_pay [STEPS+1];

	logic [PAY_W-1:0] last_pay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b1;
			cfg_q.input_mode <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				spt_pkg::CFG_ENABLE: cfg_q.enable <= cfg_data[0];
				spt_pkg::CFG_INPUT_MODE: cfg_q.input_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	spt_front #(
		.SAMPLE_WIDTH(SW),
		.ANGLE_WIDTH(AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.phase_a   (sample.phase_a),
		.phase_b   (sample.phase_b),
		.phase_c   (sample.phase_c),
		.angle     (sample.angle),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.alpha     (f_alpha),
		.beta      (f_beta),
		.zero_seq  (f_zero),
		.neg_angle (f_nang),
		.flip      (f_flip),
		.turn      (f_turn)
	);

	assign chain_valid[0] = front_valid;
	assign front_ready = chain_ready[0];
	assign chain_x[0] = spt_pkg::CORDIC_X0;
	assign chain_y[0] = '0;
	assign chain_z[0] = {f_turn, {(spt_pkg::Z_W-AW){1'b0}}};
	assign chain_pay[0] = {f_flip, f_nang, f_zero, f_beta, f_alpha};

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		spt_cordic_cell #(
			.STEP  (i),
			.PAY_W (PAY_W)
		) u_rot (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.x_in      (chain_x[i]),
			.y_in      (chain_y[i]),
			.z_in      (chain_z[i]),
			.pay_in    (chain_pay[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.x_out     (chain_x[i+1]),
			.y_out     (chain_y[i+1]),
			.z_out     (chain_z[i+1]),
			.pay_out   (chain_pay[i+1])
		);
	end

	// The residual angle of the last rotation is not needed further on.
	assign last_pay = chain_pay[STEPS];

	spt_back #(
		.SAMPLE_WIDTH(SW),
		.ANGLE_WIDTH(AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[STEPS]),
		.in_ready  (chain_ready[STEPS]),
		.x         (chain_x[STEPS]),
		.y         (chain_y[STEPS]),
		.alpha     (last_pay[SW:0]),
		.beta      (last_pay[2*SW+1:SW+1]),
		.zero_in   (last_pay[3*SW+1:2*SW+2]),
		.nang_in   (last_pay[3*SW+AW+1:3*SW+2]),
		.flip      (last_pay[PAY_W-1]),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.pos_d     (result.pos_d),
		.pos_q     (result.pos_q),
		.neg_d     (result.neg_d),
		.neg_q     (result.neg_q),
		.zero_seq  (result.zero_seq),
		.neg_angle (result.neg_angle)
	);

endmodule

FILE: rtl/spt_checker.sv
module spt_checker #(
	parameter int DATA_W = 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_ready,
	input logic              result_valid,
	input logic              result_ready,
	input logic [DATA_W-1:0] result_data
);

	// Reset empties the output register at once.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid while in reset");

	// With the output register free no stage can be stalled, so an item is taken.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("sample not ready although the output is empty");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result withdrawn under stall");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_data))
		else $error("result changed under stall");

endmodule

bind three_phase_sequence_park_transform_core spt_checker #(
	.DATA_W(4 * (SAMPLE_WIDTH + 2) + SAMPLE_WIDTH + ANGLE_WIDTH)
) u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  ({result.pos_d, result.pos_q, result.neg_d, result.neg_q,
		result.zero_seq, result.neg_angle})
);
